>>> hw/rtl/alt_pkg.sv
package alt_pkg;

    typedef enum logic [2:0] {
        ACT_FIND       = 3'd0,
        ACT_REGISTER   = 3'd1,
        ACT_UNREGISTER = 3'd2,
        ACT_READ       = 3'd3,
        ACT_SAVED      = 3'd4
    } action_t;

    typedef enum logic [1:0] {
        STATUS_OK        = 2'd0,
        STATUS_FULL      = 2'd1,
        STATUS_NOT_FOUND = 2'd2,
        STATUS_BEYOND    = 2'd3
    } status_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_MOVE_RD,
        ST_MOVE_WR,
        ST_READ,
        ST_OUT
    } state_t;

endpackage

>>> hw/rtl/allow_list_table_core.sv
// Allow-list table of card codes held in a single-port-read RAM with a count and a dirty flag.
// One request word is taken at a time; s_ready is low until its result word has been taken.
// Find, register and unregister scan the stored entries in order, one entry per cycle through
// the RAM read port, and stop at the first match. Unregister of a present code then copies the
// last entry into the freed slot (ST_MOVE_RD, ST_MOVE_WR). Read entry of a position below the
// count fetches the stored word through ST_READ, mark saved clears the dirty flag; each result
// then waits in the output stage until taken. The table starts empty after reset; no clearing pass is run.
module allow_list_table_core #(
    parameter int CAPACITY  = 64,
    parameter int CODE_BITS = 32
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [2:0]  s_action,
    input  logic [31:0] s_card_code,
    input  logic [5:0]  s_position,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [1:0]  m_status,
    output logic        m_found,
    output logic [5:0]  m_match_index,
    output logic [31:0] m_entry_code,
    output logic [6:0]  m_entry_count,
    output logic        m_dirty
);

    localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CNT_W = $clog2(CAPACITY + 1);
    localparam int CW    = (CODE_BITS > 32) ? CODE_BITS : 32;
    localparam int PW    = (CNT_W > 6) ? CNT_W : 6;
    localparam int MW    = (IDX_W > 6) ? IDX_W : 6;
    localparam int EW    = (CNT_W > 7) ? CNT_W : 7;

    alt_pkg::state_t  state_reg, state_next;
    alt_pkg::action_t action_reg, action_next;
    alt_pkg::status_t status_reg, status_next;

    logic [CODE_BITS-1:0] code_reg, code_next;
    logic [CNT_W-1:0]     idx_reg, idx_next;
    logic                 pend_reg, pend_next;
    logic [IDX_W-1:0]     pend_idx_reg, pend_idx_next;
    logic [IDX_W-1:0]     hit_idx_reg, hit_idx_next;
    logic [CNT_W-1:0]     count_reg, count_next;
    logic                 dirty_reg, dirty_next;
    logic                 found_reg, found_next;
    logic [31:0]          entry_reg, entry_next;

    logic                 ram_we;
    logic [IDX_W-1:0]     ram_waddr;
    logic [CODE_BITS-1:0] ram_wdata;
    logic [IDX_W-1:0]     ram_raddr;
    logic [CODE_BITS-1:0] ram_rdata;

    logic [CW-1:0]        card_ext;
    logic [CW-1:0]        rdata_ext;
    logic [PW-1:0]        pos_ext;
    logic [MW-1:0]        hit_ext;
    logic [EW-1:0]        count_ext;
    logic                 scan_hit;

    assign card_ext  = CW'(s_card_code);
    assign rdata_ext = CW'(ram_rdata);
    assign pos_ext   = PW'(s_position);
    assign hit_ext   = MW'(hit_idx_reg);
    assign count_ext = EW'(count_reg);
    assign scan_hit  = pend_reg && (ram_rdata == code_reg);

    alt_code_ram #(
        .DEPTH (CAPACITY),
        .WIDTH (CODE_BITS),
        .AW    (IDX_W)
    ) u_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= alt_pkg::ST_IDLE;
            count_reg <= '0;
            dirty_reg <= 1'b0;
            pend_reg  <= 1'b0;
        end else begin
            state_reg <= state_next;
            count_reg <= count_next;
            dirty_reg <= dirty_next;
            pend_reg  <= pend_next;
        end
    end

    always_ff @(posedge aclk) begin
        action_reg   <= action_next;
        status_reg   <= status_next;
        code_reg     <= code_next;
        idx_reg      <= idx_next;
        pend_idx_reg <= pend_idx_next;
        hit_idx_reg  <= hit_idx_next;
        found_reg    <= found_next;
        entry_reg    <= entry_next;
    end

    always_comb begin
        state_next    = state_reg;
        action_next   = action_reg;
        status_next   = status_reg;
        code_next     = code_reg;
        idx_next      = idx_reg;
        pend_next     = pend_reg;
        pend_idx_next = pend_idx_reg;
        hit_idx_next  = hit_idx_reg;
        count_next    = count_reg;
        dirty_next    = dirty_reg;
        found_next    = found_reg;
        entry_next    = entry_reg;
        ram_we        = 1'b0;
        ram_waddr     = hit_idx_reg;
        ram_wdata     = code_reg;
        ram_raddr     = idx_reg[IDX_W-1:0];

        case (state_reg)
            alt_pkg::ST_IDLE: begin
                if (s_valid) begin
                    action_next  = alt_pkg::action_t'(s_action);
                    code_next    = card_ext[CODE_BITS-1:0];
                    status_next  = alt_pkg::STATUS_OK;
                    found_next   = 1'b0;
                    hit_idx_next = '0;
                    entry_next   = '0;
                    idx_next     = '0;
                    pend_next    = 1'b0;
                    case (alt_pkg::action_t'(s_action))
                        alt_pkg::ACT_FIND,
                        alt_pkg::ACT_REGISTER,
                        alt_pkg::ACT_UNREGISTER: begin
                            state_next = alt_pkg::ST_SCAN;
                        end
                        alt_pkg::ACT_READ: begin
                            if (pos_ext < PW'(count_reg)) begin
                                ram_raddr  = pos_ext[IDX_W-1:0];
                                state_next = alt_pkg::ST_READ;
                            end else begin
                                status_next = alt_pkg::STATUS_BEYOND;
                                state_next  = alt_pkg::ST_OUT;
                            end
                        end
                        alt_pkg::ACT_SAVED: begin
                            dirty_next = 1'b0;
                            state_next = alt_pkg::ST_OUT;
                        end
                        default: begin
                            state_next = alt_pkg::ST_OUT;
                        end
                    endcase
                end
            end
            alt_pkg::ST_SCAN: begin
                if (scan_hit) begin
                    pend_next    = 1'b0;
                    found_next   = 1'b1;
                    hit_idx_next = pend_idx_reg;
                    if (action_reg == alt_pkg::ACT_UNREGISTER) begin
                        count_next = count_reg - CNT_W'(1);
                        dirty_next = 1'b1;
                        state_next = alt_pkg::ST_MOVE_RD;
                    end else begin
                        state_next = alt_pkg::ST_OUT;
                    end
                end else if (idx_reg < count_reg) begin
                    ram_raddr     = idx_reg[IDX_W-1:0];
                    pend_next     = 1'b1;
                    pend_idx_next = idx_reg[IDX_W-1:0];
                    idx_next      = idx_reg + CNT_W'(1);
                end else begin
                    pend_next  = 1'b0;
                    state_next = alt_pkg::ST_OUT;
                    if (action_reg == alt_pkg::ACT_REGISTER) begin
                        if (count_reg == CNT_W'(CAPACITY)) begin
                            status_next = alt_pkg::STATUS_FULL;
                        end else begin
                            ram_we     = 1'b1;
                            ram_waddr  = count_reg[IDX_W-1:0];
                            count_next = count_reg + CNT_W'(1);
                            dirty_next = 1'b1;
                        end
                    end else begin
                        status_next = alt_pkg::STATUS_NOT_FOUND;
                    end
                end
            end
            alt_pkg::ST_MOVE_RD: begin
                ram_raddr  = count_reg[IDX_W-1:0];
                state_next = alt_pkg::ST_MOVE_WR;
            end
            alt_pkg::ST_MOVE_WR: begin
                ram_we     = 1'b1;
                ram_waddr  = hit_idx_reg;
                ram_wdata  = ram_rdata;
                state_next = alt_pkg::ST_OUT;
            end
            alt_pkg::ST_READ: begin
                entry_next = rdata_ext[31:0];
                state_next = alt_pkg::ST_OUT;
            end
            alt_pkg::ST_OUT: begin
                if (m_ready) begin
                    state_next = alt_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = alt_pkg::ST_IDLE;
            end
        endcase
    end

    assign s_ready       = (state_reg == alt_pkg::ST_IDLE);
    assign m_valid       = (state_reg == alt_pkg::ST_OUT);
    assign m_status      = status_reg;
    assign m_found       = found_reg;
    assign m_match_index = hit_ext[5:0];
    assign m_entry_code  = entry_reg;
    assign m_entry_count = count_ext[6:0];
    assign m_dirty       = dirty_reg;

endmodule

>>> hw/rtl/alt_code_ram.sv
module alt_code_ram #(
    parameter int DEPTH = 64,
    parameter int WIDTH = 32,
    parameter int AW    = 6
) (
    input  logic             aclk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

>>> hw/rtl/alt_checker.sv
module alt_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_valid,
    input logic        s_ready,
    input logic [2:0]  s_action,
    input logic [31:0] s_card_code,
    input logic [5:0]  s_position,
    input logic        m_valid,
    input logic        m_ready,
    input logic [1:0]  m_status,
    input logic        m_found,
    input logic [5:0]  m_match_index,
    input logic [31:0] m_entry_code,
    input logic [6:0]  m_entry_count,
    input logic        m_dirty
);

    a_reset_clears_out: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result word valid right after reset");

    a_one_at_a_time: assert property (@(posedge aclk) disable iff (!aresetn)
        !(s_ready && m_valid))
        else $error("request taken while a result word is pending");

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_status) && $stable(m_entry_count)
            && $stable(m_found) && $stable(m_dirty))
        else $error("stalled result word changed");

    a_found_ok: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_found |-> m_status == alt_pkg::STATUS_OK)
        else $error("found with error status");

    a_beyond_clean: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_status == alt_pkg::STATUS_BEYOND |-> m_entry_code == 32'd0 && !m_found)
        else $error("out-of-range read returned data");

endmodule

bind allow_list_table_core alt_checker u_alt_checker (.*);

>>> bench/testbench.sv
`timescale 1ns / 1ps

module testbench;

    localparam int CAPACITY  = 64;
    localparam int POOL_SIZE = 72;
    localparam int N_ITEMS   = 1850;
    localparam int LIMIT     = 600000;
    localparam int QUIET_LO  = 20000;
    localparam int QUIET_HI  = 45000;
    localparam int HOLD_AT   = 3000;
    localparam int HOLD_LEN  = 400;
    localparam int IDLE_PCT  = 11;

    typedef struct {
        logic [2:0]  action;
        logic [31:0] code;
        logic [5:0]  pos;
    } request_t;

    typedef struct {
        alt_pkg::status_t status;
        logic             found;
        logic [5:0]       idx;
        logic [31:0]      code;
        logic [6:0]       count;
        logic             dirty;
    } answer_t;

    logic        aclk;
    logic        aresetn = 1'b0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    logic [2:0]  s_action = '0;
    logic [31:0] s_card_code = '0;
    logic [5:0]  s_position = '0;
    logic        m_valid;
    logic        m_ready = 1'b0;
    logic [1:0]  m_status;
    logic        m_found;
    logic [5:0]  m_match_index;
    logic [31:0] m_entry_code;
    logic [6:0]  m_entry_count;
    logic        m_dirty;

    allow_list_table_core dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_action      (s_action),
        .s_card_code   (s_card_code),
        .s_position    (s_position),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_status      (m_status),
        .m_found       (m_found),
        .m_match_index (m_match_index),
        .m_entry_code  (m_entry_code),
        .m_entry_count (m_entry_count),
        .m_dirty       (m_dirty)
    );

    request_t    pending_requests[$];
    answer_t     expected_answers[$];
    logic [31:0] card_table[CAPACITY];
    int          card_count = 0;
    logic        table_dirty = 1'b0;
    logic [31:0] card_pool[POOL_SIZE];
    int          mismatches = 0;
    int          cycle_count = 0;
    int          hold_left = 0;
    logic        quiet;

    assign quiet = (cycle_count >= QUIET_LO) && (cycle_count < QUIET_HI);

    initial begin
        aclk = 1'b0;
        forever #2 aclk = ~aclk;
    end

    function automatic int locate_card(input logic [31:0] code);
        for (int i = 0; i < card_count; i++) begin
            if (card_table[i] == code) begin
                return i;
            end
        end
        return -1;
    endfunction

    task automatic apply_request(input request_t req);
        answer_t a;
        int      hit;
        a = '{status: alt_pkg::STATUS_OK, found: 1'b0, idx: '0, code: '0, count: '0,
              dirty: 1'b0};
        hit = locate_card(req.code);
        case (req.action)
            alt_pkg::ACT_FIND: begin
                if (hit >= 0) begin
                    a.found = 1'b1;
                    a.idx = 6'(hit);
                end else begin
                    a.status = alt_pkg::STATUS_NOT_FOUND;
                end
            end
            alt_pkg::ACT_REGISTER: begin
                if (hit >= 0) begin
                    a.found = 1'b1;
                    a.idx = 6'(hit);
                end else if (card_count >= CAPACITY) begin
                    a.status = alt_pkg::STATUS_FULL;
                end else begin
                    card_table[card_count] = req.code;
                    card_count++;
                    table_dirty = 1'b1;
                end
            end
            alt_pkg::ACT_UNREGISTER: begin
                if (hit >= 0) begin
                    a.found = 1'b1;
                    a.idx = 6'(hit);
                    card_count--;
                    card_table[hit] = card_table[card_count];
                    table_dirty = 1'b1;
                end else begin
                    a.status = alt_pkg::STATUS_NOT_FOUND;
                end
            end
            alt_pkg::ACT_READ: begin
                if (req.pos < card_count) begin
                    a.code = card_table[req.pos];
                end else begin
                    a.status = alt_pkg::STATUS_BEYOND;
                end
            end
            alt_pkg::ACT_SAVED: begin
                table_dirty = 1'b0;
            end
            default: ;
        endcase
        a.count = 7'(card_count);
        a.dirty = table_dirty;
        expected_answers.push_back(a);
    endtask

    task automatic add_request(input logic [2:0] act, input logic [31:0] code,
                               input logic [5:0] pos);
        pending_requests.push_back('{action: act, code: code, pos: pos});
    endtask

    function automatic logic [31:0] pick_code();
        if ($urandom_range(99) < 90) begin
            return card_pool[$urandom_range(POOL_SIZE - 1)];
        end
        return $urandom;
    endfunction

    // phase 0 fills the table, phase 1 mixes, phase 2 drains it
    task automatic add_random_request(input int phase);
        int          roll;
        logic [2:0]  act;
        int          reg_pct;
        int          unreg_pct;
        roll = $urandom_range(99);
        case (phase)
            0:       begin reg_pct = 70; unreg_pct = 5;  end
            1:       begin reg_pct = 30; unreg_pct = 25; end
            default: begin reg_pct = 5;  unreg_pct = 70; end
        endcase
        if (roll < reg_pct) begin
            act = alt_pkg::ACT_REGISTER;
        end else if (roll < reg_pct + unreg_pct) begin
            act = alt_pkg::ACT_UNREGISTER;
        end else if (roll < reg_pct + unreg_pct + 11) begin
            act = alt_pkg::ACT_FIND;
        end else if (roll < reg_pct + unreg_pct + 20) begin
            act = alt_pkg::ACT_READ;
        end else if (roll < reg_pct + unreg_pct + 23) begin
            act = alt_pkg::ACT_SAVED;
        end else begin
            act = 3'($urandom_range(7));
        end
        add_request(act, pick_code(), 6'($urandom_range(63)));
    endtask

    task automatic note_mismatch(input string msg);
        mismatches++;
        if (mismatches <= 10) begin
            $display("%s", msg);
        end
    endtask

    // driver
    always @(posedge aclk) begin
        request_t cur;
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else begin
            if (s_valid && s_ready) begin
                cur = '{action: s_action, code: s_card_code, pos: s_position};
                apply_request(cur);
            end
            if (!s_valid || s_ready) begin
                if (pending_requests.size() != 0 &&
                    (quiet || $urandom_range(99) >= IDLE_PCT)) begin
                    cur = pending_requests.pop_front();
                    s_valid     <= 1'b1;
                    s_action    <= cur.action;
                    s_card_code <= cur.code;
                    s_position  <= cur.pos;
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // receiver: random stalls plus one long hold-off
    always @(posedge aclk) begin
        if (hold_left > 0) begin
            hold_left <= hold_left - 1;
            m_ready <= 1'b0;
        end else if (cycle_count == HOLD_AT) begin
            hold_left <= HOLD_LEN;
            m_ready <= 1'b0;
        end else begin
            m_ready <= quiet || ($urandom_range(99) >= IDLE_PCT);
        end
    end

    // monitor
    always @(posedge aclk) begin
        answer_t want;
        if (aresetn && m_valid && m_ready) begin
            if (expected_answers.size() == 0) begin
                note_mismatch($sformatf({"unexpected word: status=%0d found=%0b idx=%0d ",
                    "code=%h cnt=%0d dirty=%0b"},
                    m_status, m_found, m_match_index, m_entry_code, m_entry_count, m_dirty));
            end else begin
                want = expected_answers.pop_front();
                if (m_status !== want.status || m_found !== want.found ||
                    m_match_index !== want.idx || m_entry_code !== want.code ||
                    m_entry_count !== want.count || m_dirty !== want.dirty) begin
                    note_mismatch($sformatf({"mismatch: exp status=%0d found=%0b idx=%0d ",
                        "code=%h cnt=%0d dirty=%0b, got status=%0d found=%0b idx=%0d ",
                        "code=%h cnt=%0d dirty=%0b"},
                        want.status, want.found, want.idx, want.code, want.count, want.dirty,
                        m_status, m_found, m_match_index, m_entry_code, m_entry_count,
                        m_dirty));
                end
            end
        end
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= LIMIT) begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    initial begin
        int phase;
        int len;
        for (int i = 0; i < POOL_SIZE; i++) begin
            card_pool[i] = $urandom;
        end
        card_pool[0] = 32'h0000_0000;
        card_pool[POOL_SIZE - 1] = 32'hFFFF_FFFF;

        add_request(alt_pkg::ACT_READ, 32'h0, 6'd0);
        add_request(alt_pkg::ACT_FIND, 32'h0, 6'd0);
        add_request(alt_pkg::ACT_UNREGISTER, 32'hFFFF_FFFF, 6'd63);
        add_request(alt_pkg::ACT_REGISTER, 32'h0000_0000, 6'd0);
        add_request(alt_pkg::ACT_REGISTER, 32'hFFFF_FFFF, 6'd0);
        add_request(alt_pkg::ACT_REGISTER, 32'h1234_5678, 6'd0);
        add_request(alt_pkg::ACT_REGISTER, 32'h0000_0000, 6'd0);
        add_request(alt_pkg::ACT_FIND, 32'hFFFF_FFFF, 6'd0);
        add_request(alt_pkg::ACT_FIND, 32'hA5A5_5A5A, 6'd0);
        add_request(alt_pkg::ACT_READ, 32'h0, 6'd2);
        add_request(alt_pkg::ACT_READ, 32'h0, 6'd3);
        add_request(alt_pkg::ACT_READ, 32'h0, 6'd63);
        add_request(alt_pkg::ACT_SAVED, 32'h0, 6'd0);
        add_request(alt_pkg::ACT_REGISTER, 32'hFFFF_FFFF, 6'd0);
        add_request(alt_pkg::ACT_UNREGISTER, 32'h0000_0000, 6'd0);
        add_request(alt_pkg::ACT_READ, 32'h0, 6'd0);
        add_request(alt_pkg::ACT_UNREGISTER, 32'hFFFF_FFFF, 6'd0);
        add_request(alt_pkg::ACT_UNREGISTER, 32'h1234_5678, 6'd0);
        add_request(3'd5, $urandom, 6'd21);
        add_request(3'd6, $urandom, 6'd42);
        add_request(3'd7, 32'hFFFF_FFFF, 6'd63);
        add_request(alt_pkg::ACT_SAVED, 32'hFFFF_FFFF, 6'd63);

        phase = 0;
        while (pending_requests.size() < N_ITEMS) begin
            len = $urandom_range(260, 140);
            for (int i = 0; i < len && pending_requests.size() < N_ITEMS; i++) begin
                add_random_request(phase % 3);
            end
            phase++;
        end

        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;

        while (pending_requests.size() != 0 || s_valid) begin
            @(posedge aclk);
        end
        while (expected_answers.size() != 0) begin
            @(posedge aclk);
        end
        repeat (2 * CAPACITY) @(posedge aclk);

        if (mismatches == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule
